// ===== hw/rtl/utf8l1_pkg.sv =====
package utf8l1_pkg;

    // Character codes and byte classes
    localparam logic [7:0] QMARK      = 8'h3F;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [20:0] LATIN_MAX = 21'h0000FF;

    localparam int ACC_W = 21;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] latin_byte;
        logic       has_char;
        logic       end_of_text;
    } t_out;

endpackage

// ===== hw/rtl/utf8_to_latin1_stream.sv =====
// UTF-8 to Latin-1 stream decoder. One UTF-8 byte enters per transfer and at
// most one Latin-1 result leaves for it. The block sustains one byte per
// cycle while the output is not stalled: a byte sits in the input register,
// is decoded against the sequence state, and its result lands in the output
// register, from which it transfers when the receiver is ready. A byte that
// yields no character (a lead, a continuation, a skipped byte, or anything
// after a zero ended the text) produces no output transfer, except the byte
// marked final, which always produces exactly one result with end_of_text
// set and returns the decoder to its reset state. Code points above 0xFF,
// surrogates and invalid or truncated sequences come out as '?' (0x3F).
module utf8_to_latin1_stream (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  utf8l1_pkg::t_in     i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output utf8l1_pkg::t_out    o_out_data
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_GATHER = 2'd1,
        MODE_SKIP   = 2'd2
    } t_mode;

    // Input stage
    logic                 r_in_valid;
    utf8l1_pkg::t_in      r_in;

    // Decoder state
    t_mode                r_mode, n_mode;
    logic [1:0]           r_left, n_left;
    logic [utf8l1_pkg::ACC_W-1:0] r_acc, n_acc;
    logic                 r_ended, n_ended;

    // Output stage
    logic                 r_out_valid;
    utf8l1_pkg::t_out     r_out;

    // Decode results for the byte in the input register
    logic                 d_has;
    logic [7:0]           d_ch;
    logic                 res_valid;
    logic                 out_free;
    logic                 s1_go;

    always_comb begin
        logic [7:0]                   b;
        logic                         fin;
        logic                         cont;
        logic [utf8l1_pkg::ACC_W-1:0] cp;
        logic                         put_cp;

        b      = r_in.text_byte;
        fin    = r_in.final_byte;
        cont   = (b & utf8l1_pkg::CONT_MASK) == utf8l1_pkg::CONT_TAG;
        cp     = '0;
        put_cp = 1'b0;
        d_has  = 1'b0;
        d_ch   = 8'h00;
        n_mode = r_mode;
        n_left = r_left;
        n_acc  = r_acc;
        n_ended = r_ended;

        if (!r_ended) begin
            if (r_mode == MODE_SKIP && cont) begin
                // drop continuation bytes after a bad lead
            end else if (r_mode == MODE_GATHER) begin
                if (cont) begin
                    n_acc  = {r_acc[utf8l1_pkg::ACC_W-7:0], b[5:0]};
                    n_left = r_left - 2'd1;
                    if (n_left == 2'd0) begin
                        n_mode = MODE_IDLE;
                        cp     = n_acc;
                        put_cp = 1'b1;
                    end else if (fin) begin
                        n_mode = MODE_IDLE;
                        d_has  = 1'b1;
                        d_ch   = utf8l1_pkg::QMARK;
                    end
                end else begin
                    // broken sequence: swallow the byte
                    n_mode = MODE_IDLE;
                    n_left = 2'd0;
                    d_has  = 1'b1;
                    d_ch   = utf8l1_pkg::QMARK;
                    if (b == 8'h00) begin
                        n_ended = 1'b1;
                    end
                end
            end else begin
                n_mode = MODE_IDLE;
                if (!b[7]) begin
                    cp     = {13'd0, b};
                    put_cp = 1'b1;
                end else if ((b & utf8l1_pkg::LEAD2_MASK) == utf8l1_pkg::LEAD2_TAG) begin
                    n_acc  = {16'd0, b[4:0]};
                    n_left = 2'd1;
                    n_mode = MODE_GATHER;
                end else if ((b & utf8l1_pkg::LEAD3_MASK) == utf8l1_pkg::LEAD3_TAG) begin
                    n_acc  = {17'd0, b[3:0]};
                    n_left = 2'd2;
                    n_mode = MODE_GATHER;
                end else if ((b & utf8l1_pkg::LEAD4_MASK) == utf8l1_pkg::LEAD4_TAG) begin
                    n_acc  = {18'd0, b[2:0]};
                    n_left = 2'd3;
                    n_mode = MODE_GATHER;
                end else begin
                    n_mode = MODE_SKIP;
                    d_has  = 1'b1;
                    d_ch   = utf8l1_pkg::QMARK;
                end
                // lead on the final byte: sequence truncated
                if (n_mode == MODE_GATHER && fin) begin
                    n_mode = MODE_IDLE;
                    n_left = 2'd0;
                    d_has  = 1'b1;
                    d_ch   = utf8l1_pkg::QMARK;
                end
            end
        end

        // Emit a code point: zero ends the text, wide ones map to '?'
        if (put_cp) begin
            if (cp == '0) begin
                n_ended = 1'b1;
            end else begin
                d_has = 1'b1;
                d_ch  = (cp > utf8l1_pkg::LATIN_MAX) ? utf8l1_pkg::QMARK : cp[7:0];
            end
        end

        // Final byte returns all state to reset
        if (fin) begin
            n_mode  = MODE_IDLE;
            n_left  = 2'd0;
            n_acc   = '0;
            n_ended = 1'b0;
        end
    end

    // Advance the input stage when its result has room or needs none
    assign res_valid  = r_in.final_byte || d_has;
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_in_valid && (out_free || !res_valid);
    assign o_in_ready = !r_in_valid || s1_go;

    // Hold state, input stage and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_left      <= 2'd0;
            r_acc       <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_go) begin
                r_mode  <= n_mode;
                r_left  <= n_left;
                r_acc   <= n_acc;
                r_ended <= n_ended;
            end
            if (s1_go && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (s1_go && res_valid) begin
            r_out.latin_byte  <= d_has ? d_ch : 8'h00;
            r_out.has_char    <= d_has;
            r_out.end_of_text <= r_in.final_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/utf8l1_checker.sv =====
module utf8l1_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input utf8l1_pkg::t_in  i_in_data,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input utf8l1_pkg::t_out o_out_data
);

    // A stalled result holds until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A character is never zero
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.has_char |-> o_out_data.latin_byte != 8'h00)
        else $error("character result carries zero");

    // Only the final byte may give a result without a character
    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_char
            |-> o_out_data.end_of_text && o_out_data.latin_byte == 8'h00)
        else $error("empty result not at end of text");

endmodule

bind utf8_to_latin1_stream utf8l1_checker u_utf8l1_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== sim/utf8_to_latin1_stream_tb.sv =====
module utf8_to_latin1_stream_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BYTES_PER_PHASE = 100;
    localparam int NUM_PHASES = 4;
    localparam int NUM_DIRECTED = 27;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00E000;

    typedef enum logic [1:0] {
        SEQ_IDLE   = 2'd0,
        SEQ_GATHER = 2'd1,
        SEQ_SKIP   = 2'd2
    } t_seq_mode;

    // Decodes the byte stream alongside the DUT and checks its Latin-1 output
    class latin_scoreboard;
        t_seq_mode   seq_mode;
        logic [1:0]  cont_left;
        logic [20:0] code_point;
        logic        text_over;
        logic        char_ready;
        logic [7:0]  char_val;
        utf8l1_pkg::t_out expected_chars[$];
        int          mismatches;
        int          checked;
        int          chars_seen;
        int          ends_seen;

        function new();
            clear_state();
            mismatches = 0;
            checked    = 0;
            chars_seen = 0;
            ends_seen  = 0;
        endfunction

        function void clear_state();
            seq_mode   = SEQ_IDLE;
            cont_left  = 2'd0;
            code_point = '0;
            text_over  = 1'b0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        // Map a finished code point to Latin-1; a zero ends the text
        function void emit_code(logic [20:0] cp);
            if (cp == '0) begin
                text_over = 1'b1;
            end else begin
                char_ready = 1'b1;
                if ((cp >= SURR_LO && cp < SURR_HI) || cp > utf8l1_pkg::LATIN_MAX)
                    char_val = utf8l1_pkg::QMARK;
                else
                    char_val = cp[7:0];
            end
        endfunction

        function void emit_bad();
            char_ready = 1'b1;
            char_val   = utf8l1_pkg::QMARK;
        endfunction

        function void note_input(utf8l1_pkg::t_in item);
            logic [7:0] b;
            logic       fin;
            logic       cont;
            utf8l1_pkg::t_out res;
            b          = item.text_byte;
            fin        = item.final_byte;
            cont       = (b & utf8l1_pkg::CONT_MASK) == utf8l1_pkg::CONT_TAG;
            char_ready = 1'b0;
            char_val   = 8'h00;

            if (!text_over) begin
                if (seq_mode == SEQ_SKIP && cont) begin
                    // drop continuation bytes that follow a bad lead
                end else if (seq_mode == SEQ_GATHER) begin
                    if (cont) begin
                        code_point = {code_point[14:0], b[5:0]};
                        cont_left  = cont_left - 2'd1;
                        if (cont_left == 2'd0) begin
                            seq_mode = SEQ_IDLE;
                            emit_code(code_point);
                        end else if (fin) begin
                            seq_mode = SEQ_IDLE;
                            emit_bad();
                        end
                    end else begin
                        // broken sequence swallows the offending byte
                        seq_mode  = SEQ_IDLE;
                        cont_left = 2'd0;
                        emit_bad();
                        if (b == 8'h00)
                            text_over = 1'b1;
                    end
                end else begin
                    seq_mode = SEQ_IDLE;
                    if (b < utf8l1_pkg::CONT_TAG) begin
                        emit_code({13'd0, b});
                    end else if ((b & utf8l1_pkg::LEAD2_MASK) == utf8l1_pkg::LEAD2_TAG) begin
                        code_point = {16'd0, b[4:0]};
                        cont_left  = 2'd1;
                        seq_mode   = SEQ_GATHER;
                    end else if ((b & utf8l1_pkg::LEAD3_MASK) == utf8l1_pkg::LEAD3_TAG) begin
                        code_point = {17'd0, b[3:0]};
                        cont_left  = 2'd2;
                        seq_mode   = SEQ_GATHER;
                    end else if ((b & utf8l1_pkg::LEAD4_MASK) == utf8l1_pkg::LEAD4_TAG) begin
                        code_point = {18'd0, b[2:0]};
                        cont_left  = 2'd3;
                        seq_mode   = SEQ_GATHER;
                    end else begin
                        seq_mode = SEQ_SKIP;
                        emit_bad();
                    end
                    // a lead as the final byte is a truncated sequence
                    if (seq_mode == SEQ_GATHER && fin) begin
                        seq_mode  = SEQ_IDLE;
                        cont_left = 2'd0;
                        emit_bad();
                    end
                end
            end

            if (fin) begin
                res.latin_byte  = char_ready ? char_val : 8'h00;
                res.has_char    = char_ready;
                res.end_of_text = 1'b1;
                expected_chars.push_back(res);
                clear_state();
            end else if (char_ready) begin
                res.latin_byte  = char_val;
                res.has_char    = 1'b1;
                res.end_of_text = 1'b0;
                expected_chars.push_back(res);
            end
        endfunction

        function void check_result(utf8l1_pkg::t_out got);
            utf8l1_pkg::t_out exp;
            checked++;
            if (got.has_char === 1'b1)
                chars_seen++;
            if (got.end_of_text === 1'b1)
                ends_seen++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected result latin=%02h has=%b eot=%b",
                             got.latin_byte, got.has_char, got.end_of_text);
                return;
            end
            exp = expected_chars.pop_front();
            if (got.latin_byte !== exp.latin_byte || got.has_char !== exp.has_char ||
                got.end_of_text !== exp.end_of_text) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected latin=%02h has=%b eot=%b, ",
                              "got latin=%02h has=%b eot=%b"},
                             exp.latin_byte, exp.has_char, exp.end_of_text,
                             got.latin_byte, got.has_char, got.end_of_text);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    utf8l1_pkg::t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    utf8l1_pkg::t_out o_out_data;

    latin_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_bytes = 0;
    int quiet_cycles = 0;

    int idle_send[NUM_PHASES] = '{0, 72, 0, 20};
    int idle_recv[NUM_PHASES] = '{0, 0, 72, 20};

    // Bit 8 marks the final byte of a text
    logic [8:0] directed_text[NUM_DIRECTED] = '{
        9'h041,                          // plain ASCII
        9'h0C3, 9'h0BF,                  // top of Latin-1
        9'h0C4, 9'h080,                  // first code point past Latin-1
        9'h0ED, 9'h0A0, 9'h080,          // surrogate
        9'h0F0, 9'h09F, 9'h098, 9'h080,  // four-byte sequence
        9'h080, 9'h0BF, 9'h042,          // bad lead, skipped continuation, new lead
        9'h0FF,                          // bad lead at the top of the byte range
        9'h0C3, 9'h041,                  // sequence broken by ASCII
        9'h0E2, 9'h182,                  // sequence cut off by the final byte
        9'h0C0, 9'h080, 9'h061, 9'h100,  // overlong zero ends the text
        9'h0C3, 9'h000, 9'h162           // sequence broken by zero, text ends
    };

    utf8_to_latin1_stream u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Stall the output at random and check every transfer
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("FAIL utf8_to_latin1_stream");
            $finish;
        end
    end

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input utf8l1_pkg::t_in item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_input(item);
        sent_bytes++;
    endtask

    // Hold the input until every expected result has come out
    task automatic drain_output();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Build one text of mostly well-formed characters, then send it
    task automatic send_text();
        logic [7:0] text[$];
        logic [7:0] lead;
        int         n_chars;
        int         kind;
        int         seq_len;
        int         n_cont;
        utf8l1_pkg::t_in item;
        n_chars = $urandom_range(1, 10);
        repeat (n_chars) begin
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                lead = 8'($urandom_range(1, 127));
                if (kind == 0 && $urandom_range(0, 9) == 0)
                    lead = 8'h00;
                text.push_back(lead);
            end else if (kind < 18) begin
                if (kind < 12)
                    seq_len = 2;
                else if (kind < 15)
                    seq_len = 3;
                else if (kind < 17)
                    seq_len = 4;
                else
                    seq_len = $urandom_range(2, 4);
                case (seq_len)
                    2: lead = $urandom_range(0, 1) ? 8'hC2 | 8'($urandom_range(0, 1))
                                                   : 8'hC0 | 8'($urandom_range(0, 31));
                    3: lead = 8'hE0 | 8'($urandom_range(0, 15));
                    default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                n_cont = (kind == 17) ? $urandom_range(0, seq_len - 2) : seq_len - 1;
                text.push_back(lead);
                repeat (n_cont)
                    text.push_back(cont_byte());
            end else begin
                repeat ($urandom_range(1, 3))
                    text.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (text[i]) begin
            item.text_byte  = text[i];
            item.final_byte = (i == text.size() - 1);
            send_byte(item);
        end
    endtask

    initial begin
        utf8l1_pkg::t_in item;
        int  phase_start;
        repeat (3)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner cases first
        foreach (directed_text[i]) begin
            item.text_byte  = directed_text[i][7:0];
            item.final_byte = directed_text[i][8];
            send_byte(item);
        end
        drain_output();

        // Random texts under each idling pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            phase_start    = sent_bytes;
            while (sent_bytes - phase_start < BYTES_PER_PHASE)
                send_text();
            drain_output();
        end

        // Catch any stray result after the last expectation
        repeat (10)
            @(posedge i_clk);

        $display("%0d bytes decoded, %0d results checked (%0d characters, %0d text ends)",
                 sent_bytes, sb.checked, sb.chars_seen, sb.ends_seen);
        $display("idling: none, sender 72%%, receiver 72%%, both 20%%; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS utf8_to_latin1_stream");
        end else begin
            if (sb.pending() != 0)
                $display("%0d expected results never arrived", sb.pending());
            $display("FAIL utf8_to_latin1_stream");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/utf8l1_pkg.sv
hw/rtl/utf8_to_latin1_stream.sv
hw/rtl/utf8l1_checker.sv
sim/utf8_to_latin1_stream_tb.sv
